### design/ftbb_pkg.sv
// ----------------------------------------------------------------------------
// ftbb_pkg
// Shared types and codes for the file table with block-use bitmap: request
// and status codes, response block select, controller command and status.
// ----------------------------------------------------------------------------
package ftbb_pkg;

  // field widths
  localparam int ID_W      = 31;
  localparam int CFG_W     = 13;
  localparam int OUT_BLK_W = 12;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  // request kinds
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // response block source
  localparam logic [1:0] SEL_ZERO  = 2'd0;
  localparam logic [1:0] SEL_SLOT  = 2'd1;
  localparam logic [1:0] SEL_ALLOC = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       in_load;
    logic       clr_tbl;
    logic       sweep;
    logic       slot_start;
    logic       slot_del;
    logic       bm_start;
    logic       free_rd;
    logic       free_wr;
    logic       alloc;
    logic       resp_load;
    logic [1:0] resp_status;
    logic [1:0] resp_blk_sel;
  } ftbb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_busy;
    logic slot_hit;
    logic bm_busy;
    logic bm_hit;
    logic sweep_last;
  } ftbb_stat_t;

endpackage

### design/file_table_block_bitmap.sv
// lookup and failed delete run the slot scan; delete then reads and rewrites the bitmap
//   word; create adds the bitmap search, one 8-bit word per cycle up to min(usable_blocks/8,
//   MAX_BLOCKS/8) words, then the allocation write; clear sweeps all MAX_BLOCKS/8 words
// throughput: one request at a time, set by the slot scan (one slot per cycle) and the
//   bitmap ram port (one word per cycle)
// reset: synchronous active low; afterwards the bitmap is swept clear, MAX_BLOCKS/8 words
//   (512 by default) while in_tready stays low; cfg writes are taken throughout
// ----------------------------------------------------------------------------
// file_table_block_bitmap
// File table with a first-fit block-use bitmap: create, delete, lookup and
// clear requests, one result beat per request.
// ----------------------------------------------------------------------------
module file_table_block_bitmap #(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_BLOCKS  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: usable_blocks in [12:0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata,
  // request: tdata = file_id [30:0]; tuser = req_type [1:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  // result: tdata = block_index [11:0]; tuser = status [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);
  import ftbb_pkg::*;

  ftbb_cmd_t            cmd;
  ftbb_stat_t           stat;
  logic [OUT_BLK_W-1:0] out_block;
  logic [1:0]           out_status;

  assign cfg_tready = 1'b1;

  // sequencer
  ftbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // tables, bitmap and result register
  ftbb_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_tvalid && cfg_tready),
    .cfg_data   (cfg_tdata[CFG_W-1:0]),
    .in_id      (in_tdata[ID_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_block  (out_block)
  );

  // result beat packing
  assign out_tdata = {{(16 - OUT_BLK_W){1'b0}}, out_block};
  assign out_tuser = out_status;

endmodule

### design/ftbb_datapath.sv
// ----------------------------------------------------------------------------
// ftbb_datapath
// Slot table memory with valid bits, bitmap ram of 8-bit words, the scan
// pipelines over both, allocation and free read-modify-write, counters and
// the result register.
// ----------------------------------------------------------------------------
module ftbb_datapath #(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_BLOCKS  = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ftbb_pkg::CFG_W-1:0]     cfg_data,
  input  logic [ftbb_pkg::ID_W-1:0]      in_id,
  input  ftbb_pkg::ftbb_cmd_t            cmd,
  output ftbb_pkg::ftbb_stat_t           stat,
  output logic [1:0]                     out_status,
  output logic [ftbb_pkg::OUT_BLK_W-1:0] out_block
);
  import ftbb_pkg::*;

  localparam int BM_WORDS = MAX_BLOCKS / 8;
  localparam int WAW      = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
  localparam int NWW      = $clog2(BM_WORDS + 1);
  localparam int BW       = WAW + 3;
  localparam int SIW      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SCW      = SIW + 1;

  // lowest clear bit of a bitmap word
  function automatic logic [2:0] lowest_zero(input logic [7:0] w);
    logic [2:0] r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!w[k]) r = 3'(k);
    end
    return r;
  endfunction

  logic [CFG_W-1:0]       usable_r;
  logic [ID_W-1:0]        req_id_r;

  // slot table
  logic [ID_W-1:0]        slot_id_mem  [TABLE_SLOTS];
  logic [BW-1:0]          slot_blk_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_valid_r;
  logic [ID_W-1:0]        id_rd_r;
  logic [BW-1:0]          blk_rd_r;
  logic [SCW-1:0]         si_r;
  logic [SIW-1:0]         sc_idx_r;
  logic                   sc_v_r;
  logic                   slot_run_r;
  logic                   slot_del_r;
  logic                   slot_hit_r;
  logic [BW-1:0]          first_blk_r;
  logic                   slot_issue;
  logic                   sc_match;

  // bitmap
  logic [7:0]             bm_mem [BM_WORDS];
  logic [7:0]             bm_rdata_r;
  logic [NWW-1:0]         bi_r;
  logic [WAW-1:0]         bc_addr_r;
  logic                   bc_v_r;
  logic                   bm_run_r;
  logic                   bm_hit_r;
  logic [WAW-1:0]         hit_addr_r;
  logic [7:0]             hit_word_r;
  logic [WAW-1:0]         sw_r;
  logic                   sw_last;
  logic [31:0]            grp_w;
  logic [31:0]            lim_w;
  logic [NWW-1:0]         bm_lim;
  logic                   bm_issue;
  logic                   bc_hit;
  logic [2:0]             alloc_bit;
  logic [BW-1:0]          alloc_blk;
  logic                   bm_we;
  logic [WAW-1:0]         bm_waddr;
  logic [WAW-1:0]         bm_raddr;
  logic [7:0]             bm_wdata;

  // insert position and live count
  logic [SIW-1:0]         insert_pos_r;
  logic                   insert_none_r;
  logic [CNT_W-1:0]       live_cnt_r;
  logic [SIW-1:0]         new_pos;
  logic [CNT_W-1:0]       cnt_dec;

  logic [1:0]             out_status_r;
  logic [OUT_BLK_W-1:0]   out_block_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= '0;
    end else if (cfg_we) begin
      usable_r <= cfg_data;
    end
  end

  // request id
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_id_r <= in_id;
    end
  end

  // slot scan, one slot read per beat, compare in the cycle after
  assign slot_issue = slot_run_r && (si_r < SCW'(TABLE_SLOTS));
  assign sc_match   = sc_v_r && slot_valid_r[sc_idx_r] && (id_rd_r == req_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_run_r <= 1'b0;
      sc_v_r     <= 1'b0;
      si_r       <= '0;
      slot_hit_r <= 1'b0;
      slot_del_r <= 1'b0;
    end else if (cmd.slot_start) begin
      slot_run_r <= 1'b1;
      sc_v_r     <= 1'b0;
      si_r       <= '0;
      slot_hit_r <= 1'b0;
      slot_del_r <= cmd.slot_del;
    end else if (slot_run_r) begin
      sc_v_r <= slot_issue;
      if (slot_issue) si_r <= si_r + 1'b1;
      if (sc_match) slot_hit_r <= 1'b1;
      if (!slot_issue && !sc_v_r) slot_run_r <= 1'b0;
    end
  end

  // first matching block
  always_ff @(posedge clk) begin
    if (slot_run_r && sc_match && !slot_hit_r) begin
      first_blk_r <= blk_rd_r;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      slot_id_mem[new_pos]  <= req_id_r;
      slot_blk_mem[new_pos] <= alloc_blk;
    end
    if (slot_issue) begin
      id_rd_r  <= slot_id_mem[si_r[SIW-1:0]];
      blk_rd_r <= slot_blk_mem[si_r[SIW-1:0]];
      sc_idx_r <= si_r[SIW-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_tbl) begin
      slot_valid_r <= '0;
    end else if (cmd.alloc) begin
      slot_valid_r[new_pos] <= 1'b1;
    end else if (slot_run_r && slot_del_r && sc_match) begin
      slot_valid_r[sc_idx_r] <= 1'b0;
    end
  end

  // insert position and live count
  assign new_pos = insert_none_r ? '0 :
                   (insert_pos_r == SIW'(TABLE_SLOTS - 1)) ? '0 : insert_pos_r + 1'b1;
  assign cnt_dec = (live_cnt_r != '0) ? live_cnt_r - 1'b1 : live_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_tbl) begin
      live_cnt_r    <= '0;
      insert_none_r <= 1'b1;
      insert_pos_r  <= '0;
    end else if (cmd.alloc) begin
      insert_pos_r  <= new_pos;
      insert_none_r <= 1'b0;
      if (live_cnt_r != COUNT_MAX) live_cnt_r <= live_cnt_r + 1'b1;
    end else if (cmd.free_wr) begin
      live_cnt_r <= cnt_dec;
      if (cnt_dec == '0) begin
        insert_none_r <= 1'b1;
        insert_pos_r  <= '0;
      end
    end
  end

  // bitmap scan limit: whole groups of eight, clamped to the bitmap
  assign grp_w  = 32'(usable_r[CFG_W-1:3]);
  assign lim_w  = (grp_w > 32'(BM_WORDS)) ? 32'(BM_WORDS) : grp_w;
  assign bm_lim = lim_w[NWW-1:0];

  assign bm_issue = bm_run_r && (bi_r < bm_lim);
  assign bc_hit   = bc_v_r && (bm_rdata_r != 8'hFF);

  // bitmap scan, one word per beat, stop at the first word with a clear bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_run_r <= 1'b0;
      bc_v_r   <= 1'b0;
      bi_r     <= '0;
      bm_hit_r <= 1'b0;
    end else if (cmd.bm_start) begin
      bm_run_r <= 1'b1;
      bc_v_r   <= 1'b0;
      bi_r     <= '0;
      bm_hit_r <= 1'b0;
    end else if (bm_run_r) begin
      bc_v_r <= bm_issue;
      if (bm_issue) bi_r <= bi_r + 1'b1;
      if (bc_hit) begin
        bm_run_r <= 1'b0;
        bm_hit_r <= 1'b1;
      end else if (!bm_issue && !bc_v_r) begin
        bm_run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bm_issue) begin
      bc_addr_r <= bi_r[WAW-1:0];
    end
    if (bm_run_r && bc_hit) begin
      hit_addr_r <= bc_addr_r;
      hit_word_r <= bm_rdata_r;
    end
  end

  // clearing sweep counter
  assign sw_last = (sw_r == WAW'(BM_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_tbl) begin
      sw_r <= '0;
    end else if (cmd.sweep) begin
      sw_r <= sw_last ? '0 : sw_r + 1'b1;
    end
  end

  // bitmap ram port
  assign alloc_bit = lowest_zero(hit_word_r);
  assign alloc_blk = {hit_addr_r, alloc_bit};
  assign bm_we     = cmd.sweep || cmd.free_wr || cmd.alloc;
  assign bm_raddr  = cmd.free_rd ? first_blk_r[BW-1:3] : bi_r[WAW-1:0];

  always_comb begin
    if (cmd.sweep) begin
      bm_waddr = sw_r;
      bm_wdata = 8'h00;
    end else if (cmd.alloc) begin
      bm_waddr = hit_addr_r;
      bm_wdata = hit_word_r | (8'h01 << alloc_bit);
    end else begin
      bm_waddr = first_blk_r[BW-1:3];
      bm_wdata = bm_rdata_r & ~(8'h01 << first_blk_r[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_issue || cmd.free_rd) begin
      bm_rdata_r <= bm_mem[bm_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_status_r <= cmd.resp_status;
      case (cmd.resp_blk_sel)
        SEL_SLOT:  out_block_r <= OUT_BLK_W'(first_blk_r);
        SEL_ALLOC: out_block_r <= OUT_BLK_W'(alloc_blk);
        default:   out_block_r <= '0;
      endcase
    end
  end

  assign out_status = out_status_r;
  assign out_block  = out_block_r;

  assign stat.slot_busy  = slot_run_r;
  assign stat.slot_hit   = slot_hit_r;
  assign stat.bm_busy    = bm_run_r;
  assign stat.bm_hit     = bm_hit_r;
  assign stat.sweep_last = sw_last;

  // checks
  a_alloc_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> (bm_hit_r && !bm_run_r))
    else $error("allocation without a finished bitmap hit");

  a_scans_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(slot_run_r && bm_run_r))
    else $error("slot scan and bitmap scan overlap");

  a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (live_cnt_r != $past(live_cnt_r)))
      |-> $past(cmd.alloc || cmd.free_wr || cmd.clr_tbl))
    else $error("live count changed without create, delete or clear");

endmodule

### design/ftbb_ctrl.sv
// ----------------------------------------------------------------------------
// ftbb_ctrl
// Request sequencer: clearing sweep, slot scan, bitmap search, allocation or
// free, then the result beat into the output register.
// ----------------------------------------------------------------------------
module ftbb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_req,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  ftbb_pkg::ftbb_stat_t stat,
  output ftbb_pkg::ftbb_cmd_t  cmd
);
  import ftbb_pkg::*;

  localparam logic [3:0] S_SWEEP   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SLOT_GO = 4'd2;
  localparam logic [3:0] S_SLOT    = 4'd3;
  localparam logic [3:0] S_BM_GO   = 4'd4;
  localparam logic [3:0] S_BM      = 4'd5;
  localparam logic [3:0] S_ALLOC   = 4'd6;
  localparam logic [3:0] S_FREE_RD = 4'd7;
  localparam logic [3:0] S_FREE_WR = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [1:0] req_r, req_nxt;
  logic [1:0] st_r, st_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       clr_pend_r, clr_pend_nxt;
  logic       out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    st_nxt       = st_r;
    sel_nxt      = sel_r;
    clr_pend_nxt = clr_pend_r;
    cmd          = '0;
    cmd.resp_status  = st_r;
    cmd.resp_blk_sel = sel_r;
    in_tready    = (state_r == S_IDLE);
    case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt    = clr_pend_r ? S_RESP : S_IDLE;
          clr_pend_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          req_nxt     = in_req;
          if (in_req == REQ_CLEAR) begin
            cmd.clr_tbl  = 1'b1;
            clr_pend_nxt = 1'b1;
            st_nxt       = ST_OK;
            sel_nxt      = SEL_ZERO;
            state_nxt    = S_SWEEP;
          end else begin
            state_nxt = S_SLOT_GO;
          end
        end
      end
      S_SLOT_GO: begin
        cmd.slot_start = 1'b1;
        cmd.slot_del   = (req_r == REQ_DELETE);
        state_nxt      = S_SLOT;
      end
      S_SLOT: begin
        if (!stat.slot_busy) begin
          case (req_r)
            REQ_CREATE: begin
              if (stat.slot_hit) begin
                st_nxt    = ST_EXISTS;
                sel_nxt   = SEL_SLOT;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_BM_GO;
              end
            end
            REQ_DELETE: begin
              if (stat.slot_hit) begin
                state_nxt = S_FREE_RD;
              end else begin
                st_nxt    = ST_NOTFOUND;
                sel_nxt   = SEL_ZERO;
                state_nxt = S_RESP;
              end
            end
            default: begin
              st_nxt    = stat.slot_hit ? ST_OK : ST_NOTFOUND;
              sel_nxt   = stat.slot_hit ? SEL_SLOT : SEL_ZERO;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_BM_GO: begin
        cmd.bm_start = 1'b1;
        state_nxt    = S_BM;
      end
      S_BM: begin
        if (!stat.bm_busy) begin
          if (stat.bm_hit) begin
            state_nxt = S_ALLOC;
          end else begin
            st_nxt    = ST_FULL;
            sel_nxt   = SEL_ZERO;
            state_nxt = S_RESP;
          end
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        st_nxt    = ST_OK;
        sel_nxt   = SEL_ALLOC;
        state_nxt = S_RESP;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        st_nxt      = ST_OK;
        sel_nxt     = SEL_SLOT;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      req_r      <= REQ_CREATE;
      st_r       <= ST_OK;
      sel_r      <= SEL_ZERO;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      req_r      <= req_nxt;
      st_r       <= st_nxt;
      sel_r      <= sel_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(cmd.resp_load))
    else $error("result valid raised without a result load");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_tvalid) |=> (state_r == S_IDLE))
    else $error("left idle without a request");

endmodule

### tb/sv/ftbb_checker.sv
// ----------------------------------------------------------------------------
// ftbb_checker
// Passive checker for the file table with block-use bitmap. It follows
// register writes and request beats, keeps its own copy of the table, the
// bitmap and the counters, and compares every result beat with the oldest
// predicted response.
// ----------------------------------------------------------------------------
module ftbb_checker
  import ftbb_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int MAX_BLOCKS  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  input  logic        cfg_tready,
  input  logic [15:0] cfg_tdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          resp_due
);

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_BLK_W-1:0] blk;
  } file_resp_t;

  // shadow copy of the register and the block state
  logic [CFG_W-1:0] usable_q;
  bit               used_map [MAX_BLOCKS];
  logic [ID_W-1:0]  slot_id  [TABLE_SLOTS];
  int               slot_blk [TABLE_SLOTS];
  bit               slot_on  [TABLE_SLOTS];
  int               insert_pos;
  bit               insert_none;
  logic [CNT_W-1:0] live_cnt;

  // responses owed by the block, oldest first
  file_resp_t       resp_q[$];

  function automatic void wipe_table();
    int k;
    for (k = 0; k < MAX_BLOCKS; k++) used_map[k] = 1'b0;
    for (k = 0; k < TABLE_SLOTS; k++) begin
      slot_id[k]  = '0;
      slot_blk[k] = 0;
      slot_on[k]  = 1'b0;
    end
    insert_pos  = 0;
    insert_none = 1'b1;
    live_cnt    = '0;
  endfunction

  // first valid slot holding id, TABLE_SLOTS when absent
  function automatic int find_slot(input logic [ID_W-1:0] id);
    int k;
    for (k = 0; k < TABLE_SLOTS; k++)
      if (slot_on[k] && slot_id[k] == id) return k;
    return TABLE_SLOTS;
  endfunction

  // applies one request to the shadow state and returns its response
  function automatic file_resp_t serve_request(input logic [1:0] req,
                                               input logic [ID_W-1:0] id);
    file_resp_t r;
    int s, b, k, n, lim;
    bit found;
    r.status = ST_OK;
    r.blk    = '0;
    case (req)
      REQ_CREATE: begin
        s = find_slot(id);
        if (s < TABLE_SLOTS) begin
          r.status = ST_EXISTS;
          r.blk    = OUT_BLK_W'(slot_blk[s]);
        end else begin
          // first fit over whole groups of eight
          n = int'(usable_q);
          if (n > MAX_BLOCKS) n = MAX_BLOCKS;
          lim   = (n / 8) * 8;
          found = 1'b0;
          b     = 0;
          for (k = 0; k < lim && !found; k++)
            if (!used_map[k]) begin
              b     = k;
              found = 1'b1;
            end
          if (!found) begin
            r.status = ST_FULL;
          end else begin
            used_map[b] = 1'b1;
            if (insert_none) begin
              insert_pos  = 0;
              insert_none = 1'b0;
            end else begin
              insert_pos = (insert_pos + 1) % TABLE_SLOTS;
            end
            // an occupied slot is overwritten, its block stays marked
            slot_id[insert_pos]  = id;
            slot_blk[insert_pos] = b;
            slot_on[insert_pos]  = 1'b1;
            if (live_cnt < COUNT_MAX) live_cnt = live_cnt + 1'b1;
            r.blk = OUT_BLK_W'(b);
          end
        end
      end
      REQ_DELETE: begin
        s = find_slot(id);
        if (s >= TABLE_SLOTS) begin
          r.status = ST_NOTFOUND;
        end else begin
          b     = slot_blk[s];
          r.blk = OUT_BLK_W'(b);
          if (b < MAX_BLOCKS) used_map[b] = 1'b0;
          for (k = 0; k < TABLE_SLOTS; k++)
            if (slot_on[k] && slot_id[k] == id) slot_on[k] = 1'b0;
          if (live_cnt != '0) live_cnt = live_cnt - 1'b1;
          if (live_cnt == '0) begin
            insert_pos  = 0;
            insert_none = 1'b1;
          end
        end
      end
      REQ_LOOKUP: begin
        s = find_slot(id);
        if (s >= TABLE_SLOTS) r.status = ST_NOTFOUND;
        else                  r.blk    = OUT_BLK_W'(slot_blk[s]);
      end
      default: wipe_table();
    endcase
    return r;
  endfunction

  // beat tracking on all three channels
  always @(posedge clk) begin
    file_resp_t want;
    if (!rst_n) begin
      usable_q = '0;
      wipe_table();
      resp_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (resp_q.size() == 0) begin
          errors++;
          $error("result beat with nothing outstanding: status %0d block_index %0d",
                 out_tuser, out_tdata[OUT_BLK_W-1:0]);
        end else begin
          want = resp_q.pop_front();
          if (out_tuser !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
          end
          if (out_tdata[OUT_BLK_W-1:0] !== want.blk) begin
            errors++;
            $error("block_index: expected %0d, actual %0d",
                   want.blk, out_tdata[OUT_BLK_W-1:0]);
          end
        end
      end
      if (cfg_tvalid && cfg_tready) usable_q = cfg_tdata[CFG_W-1:0];
      if (in_tvalid && in_tready)
        resp_q.push_back(serve_request(in_tuser, in_tdata[ID_W-1:0]));
    end
    resp_due = resp_q.size();
  end

endmodule

### tb/sv/tb_file_table_block_bitmap.sv
// ----------------------------------------------------------------------------
// tb_file_table_block_bitmap
// Drives the file table with create, delete, lookup and clear requests under
// a range of usable_blocks settings, with random gaps and result stalls and
// one long result hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_file_table_block_bitmap;
  import ftbb_pkg::*;

  localparam int N_PHASE      = 10;
  localparam int PHASE_ITEMS  = 140;
  localparam int POOL         = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT_BEAT = 600;
  localparam int LIMIT_CYCLES = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [15:0] cfg_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // file_id [30:0]
  logic [1:0]  in_tuser;   // req_type [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // block_index [11:0]
  logic [1:0]  out_tuser;  // status [1:0]

  int errors;
  int resp_due;
  int op_count [4];
  int settings;
  bit quiet;
  logic [ID_W-1:0] id_pool [POOL];

  file_table_block_bitmap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ftbb_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .resp_due   (resp_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

  // one request beat, after a random gap
  task automatic send_req(input logic [1:0] req, input logic [ID_W-1:0] id);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, id};
    do @(posedge clk); while (in_tready !== 1'b1);
    op_count[req]++;
  endtask

  // stop offering and wait for every owed response
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (resp_due != 0);
    @(posedge clk);
  endtask

  task automatic write_usable(input int value);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= 16'(value);
    do @(posedge clk); while (cfg_tready !== 1'b1);
    cfg_tvalid <= 1'b0;
    settings++;
  endtask

  function automatic int phase_usable(input int p);
    case (p)
      0:       return 24;
      1:       return 8191;
      2:       return 16;
      3:       return 4096;
      4:       return 9;
      5:       return 64;
      6:       return 4095;
      7:       return 33;
      8:       return 5000;
      default: return 200;
    endcase
  endfunction

  // mostly ids from a small pool so requests hit each other
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 8) return id_pool[$urandom_range(0, POOL - 1)];
    return ID_W'($urandom);
  endfunction

  // result side: random stalls, one long hold-off mid-run
  initial begin
    int stall;
    int beats;
    beats      = 0;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (beats == HOLD_AT_BEAT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      beats++;
    end
  end

  // request side and verdict
  initial begin
    int p, r, create_pct, k;
    logic [1:0] req;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_CREATE;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    quiet      = 1'b0;
    settings   = 0;
    for (k = 0; k < 4; k++) op_count[k] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // no usable blocks: every create reports a full bitmap
    write_usable(0);
    send_req(REQ_CREATE, {ID_W{1'b1}});
    send_req(REQ_LOOKUP, {ID_W{1'b1}});
    send_req(REQ_DELETE, {ID_W{1'b1}});
    drain();
    // fewer than one whole group still searches nothing
    write_usable(7);
    send_req(REQ_CREATE, 31'd3);
    drain();
    // one group of eight: exists, delete to zero count, refill, full, clear
    write_usable(8);
    send_req(REQ_CREATE, '0);
    send_req(REQ_CREATE, {ID_W{1'b1}});
    send_req(REQ_CREATE, '0);
    send_req(REQ_LOOKUP, {ID_W{1'b1}});
    send_req(REQ_DELETE, '0);
    send_req(REQ_LOOKUP, '0);
    send_req(REQ_DELETE, {ID_W{1'b1}});
    send_req(REQ_CREATE, 31'h5555_5555);
    send_req(REQ_CREATE, 31'h2AAA_AAAA);
    for (k = 1; k <= 6; k++) send_req(REQ_CREATE, ID_W'(k));
    send_req(REQ_CREATE, 31'd7);
    send_req(REQ_LOOKUP, 31'd6);
    send_req(REQ_CLEAR, 31'd6);
    send_req(REQ_LOOKUP, 31'd6);
    send_req(REQ_CREATE, 31'd6);

    // random phases, one register setting each
    for (p = 0; p < N_PHASE; p++) begin
      drain();
      write_usable(phase_usable(p));
      id_pool[0] = {ID_W{1'b1}};
      id_pool[1] = '0;
      for (k = 2; k < POOL; k++)
        id_pool[k] = (k % 2) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
      quiet      = (p % 4 == 2);
      create_pct = (phase_usable(p) >= 4096) ? 65 : 45;
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 2)                              req = REQ_CLEAR;
        else if (r < 2 + create_pct)            req = REQ_CREATE;
        else if (r < 2 + create_pct + (98 - create_pct) / 2) req = REQ_DELETE;
        else                                    req = REQ_LOOKUP;
        send_req(req, pick_id());
      end
    end

    // let the last responses arrive, then a short tail
    in_tvalid <= 1'b0;
    do @(negedge clk); while (resp_due != 0);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: %0d create, %0d delete, %0d lookup, %0d clear",
             op_count[REQ_CREATE] + op_count[REQ_DELETE] + op_count[REQ_LOOKUP]
             + op_count[REQ_CLEAR], op_count[REQ_CREATE], op_count[REQ_DELETE],
             op_count[REQ_LOOKUP], op_count[REQ_CLEAR]);
    $display("%0d usable_blocks settings from 0 to 8191, one %0d-cycle result hold-off",
             settings, HOLD_CYCLES);
    if (errors == 0 && resp_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
